// ===== hw/rtl/vh256_pkg.sv =====
// ----------------------------------------------------------------------------
// vh256_pkg
// Types and constants used by the heading unit.
// ----------------------------------------------------------------------------
`default_nettype none

package vh256_pkg;

    // Sequencer states, one-hot.
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_ABS   = 6'b000010,
        S_ORDER = 6'b000100,
        S_NORM  = 6'b001000,
        S_DIV   = 6'b010000,
        S_FIN   = 6'b100000
    } t_state;

    // Compass offsets and special codes.
    localparam logic [7:0] BASE_WEST  = 8'hC0;
    localparam logic [7:0] OCT_FLIP   = 8'h40;
    localparam logic [7:0] OCT_FLIP_M = 8'h3F;
    localparam logic [7:0] NO_DIR     = 8'hFF;
    localparam logic [7:0] HALF_STEP  = 8'h10;

    // Divider: nine quotient bits, counted 0 to 8.
    localparam logic [3:0] DIV_LAST   = 4'd8;

    // Register map: byte address bit 2 selects the register index.
    localparam int         ADDR_WIDTH = 3;
    localparam logic       REG_EIGHT_WAY = 1'b0;
    localparam int         DATA_WIDTH = 32;

endpackage

`default_nettype wire

// ===== hw/rtl/vector_heading_256_unit.sv =====
// ----------------------------------------------------------------------------
// vector_heading_256_unit
// Heading on a 256-step compass from a source point to a target point.
// ----------------------------------------------------------------------------
// Usage:
// An input transaction (i_valid/i_ready) carries two points; one output
// transaction (o_valid/o_ready) returns the heading, 0 north, 63 east,
// 127 south, 192 west. Equal points give 255 outside eight-way mode.
// The eight_way_mode register (byte address 0) rounds the heading to one of
// eight directions. The user must write it over the APB-style port only
// while idle; the block does not enforce this. After acceptance the unit
// takes the absolute differences, orders them, then normalises them with k
// single-bit shifts (0 to COORD_WIDTH - 8, eight at the default width), one
// bit per cycle, and runs the nine-step restoring divider on the subtractor
// it shares with the order step; the final state then hands out the result.
// i_ready is high only while the sequencer is idle. A finished heading sits
// in the output register, so the next transaction may be accepted while the
// receiver stalls; a second result then waits in the final state.
// The synchronous reset clears the sequencer, o_valid and the mode register.
// ----------------------------------------------------------------------------
`default_nettype none

module vector_heading_256_unit #(
    parameter int COORD_WIDTH = 16
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_valid,
    output logic                                      i_ready,
    input  wire logic signed [COORD_WIDTH-1:0]        i_from_x,
    input  wire logic signed [COORD_WIDTH-1:0]        i_from_y,
    input  wire logic signed [COORD_WIDTH-1:0]        i_to_x,
    input  wire logic signed [COORD_WIDTH-1:0]        i_to_y,
    output logic                                      o_valid,
    input  wire logic                                 o_ready,
    output logic [7:0]                                o_heading,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [vh256_pkg::ADDR_WIDTH-1:0]     paddr,
    input  wire logic [vh256_pkg::DATA_WIDTH-1:0]     pwdata,
    output logic [vh256_pkg::DATA_WIDTH-1:0]          prdata,
    output logic                                      pready
);
    import vh256_pkg::*;

    localparam int DW = COORD_WIDTH + 1;   // magnitude of a difference
    localparam int SW = DW + 1;            // subtractor width, with borrow

    t_state              r_state, n_state;
    logic signed [DW-1:0] r_dxs, n_dxs, r_dys, n_dys;
    logic [DW-1:0]       r_minor, n_minor, r_major, n_major, r_rem, n_rem;
    logic [7:0]          r_base, n_base;
    logic                r_off, n_off;
    logic [8:0]          r_q, n_q;
    logic [3:0]          r_cnt, n_cnt;
    logic                r_ovalid, n_ovalid;
    logic [7:0]          r_heading, n_heading;
    logic                r_eight;

    // Shared subtractor: compares the differences, then runs the divider.
    logic [SW-1:0]       sub_a, sub_b, sub_d;
    logic                sub_ge;

    logic                out_free;
    logic [DW-1:0]       abs_x, abs_y;
    logic [7:0]          h_ratio, h_fold, h_full, h_round, h_final;
    logic                cfg_wr;

    assign i_ready   = (r_state == S_IDLE);
    assign o_valid   = r_ovalid;
    assign o_heading = r_heading;
    assign pready    = 1'b1;
    assign out_free  = !r_ovalid || o_ready;

    always_comb begin
        unique case (r_state)
            S_ORDER: begin
                sub_a = {1'b0, r_minor};
                sub_b = {1'b0, r_major};
            end
            S_DIV: begin
                sub_a = (r_cnt == '0) ? {1'b0, r_rem} : {r_rem, 1'b0};
                sub_b = {1'b0, r_major};
            end
            default: begin
                sub_a = '0;
                sub_b = '0;
            end
        endcase
        sub_d  = sub_a - sub_b;
        sub_ge = !sub_d[SW-1];
    end

    // Absolute differences.
    assign abs_x = r_dxs[DW-1] ? DW'(-r_dxs) : DW'(r_dxs);
    assign abs_y = r_dys[DW-1] ? DW'(-r_dys) : DW'(r_dys);

    // Fold the ratio into the octant, add the octant base and round for eight-way mode.
    always_comb begin
        h_ratio = (r_major == '0) ? NO_DIR : {2'b00, r_q[8:3]};
        h_fold  = r_off ? 8'(8'd0 - h_ratio + OCT_FLIP_M) : h_ratio;
        h_full  = 8'(h_fold + r_base);
        h_round = 8'(h_full + HALF_STEP);
        h_final = r_eight ? {h_round[7:5], 5'b00000} : h_full;
    end

    always_comb begin
        n_state   = r_state;
        n_dxs     = r_dxs;
        n_dys     = r_dys;
        n_minor   = r_minor;
        n_major   = r_major;
        n_rem     = r_rem;
        n_base    = r_base;
        n_off     = r_off;
        n_q       = r_q;
        n_cnt     = r_cnt;
        n_ovalid  = (r_ovalid && !o_ready);
        n_heading = r_heading;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_dxs   = DW'({i_to_x[COORD_WIDTH-1], i_to_x}
                                  - {i_from_x[COORD_WIDTH-1], i_from_x});
                    n_dys   = DW'({i_from_y[COORD_WIDTH-1], i_from_y}
                                  - {i_to_y[COORD_WIDTH-1], i_to_y});
                    n_state = S_ABS;
                end
            end
            S_ABS: begin
                // Minor takes dy and major dx until the order step.
                n_minor = abs_y;
                n_major = abs_x;
                n_base  = (r_dxs[DW-1] ? BASE_WEST : 8'h00)
                          ^ (r_dys[DW-1] ? OCT_FLIP : 8'h00);
                n_off   = !n_base[6];
                n_state = S_ORDER;
            end
            S_ORDER: begin
                if (sub_ge) begin
                    n_minor = r_major;
                    n_major = r_minor;
                    n_off   = !r_off;
                end
                n_state = S_NORM;
            end
            S_NORM: begin
                if (~|r_minor[DW-1:8] && |r_major[DW-1:8]) begin
                    n_minor = r_minor >> 1;
                    n_major = r_major >> 1;
                end else begin
                    n_rem   = r_minor;
                    n_cnt   = '0;
                    n_q     = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_rem = sub_ge ? sub_d[DW-1:0] : sub_a[DW-1:0];
                n_q   = {r_q[7:0], sub_ge};
                n_cnt = 4'(r_cnt + 4'd1);
                if (r_cnt == DIV_LAST) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_ovalid  = 1'b1;
                    n_heading = h_final;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dxs     <= n_dxs;
        r_dys     <= n_dys;
        r_minor   <= n_minor;
        r_major   <= n_major;
        r_rem     <= n_rem;
        r_base    <= n_base;
        r_off     <= n_off;
        r_q       <= n_q;
        r_cnt     <= n_cnt;
        r_heading <= n_heading;
    end

    // Configuration register.
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_EIGHT_WAY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eight <= 1'b0;
        end else if (cfg_wr) begin
            r_eight <= pwdata[0];
        end
    end

    assign prdata = (paddr[2] == REG_EIGHT_WAY) ? {{(DATA_WIDTH-1){1'b0}}, r_eight} : '0;

endmodule

`default_nettype wire

// ===== hw/rtl/vh256_checker.sv =====
// ----------------------------------------------------------------------------
// vh256_checker
// Port-level checks on the heading unit, attached by a bind statement.
// ----------------------------------------------------------------------------
`default_nettype none

module vh256_checker (
    input wire logic                                 i_clk,
    input wire logic                                 i_rst_n,
    input wire logic                                 i_valid,
    input wire logic                                 i_ready,
    input wire logic                                 o_valid,
    input wire logic                                 o_ready,
    input wire logic [7:0]                           o_heading,
    input wire logic                                 pready
);

    // Reset empties the output register.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("o_valid high after reset");

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_ready) |=> (o_valid && $stable(o_heading)))
        else $error("stalled heading changed or dropped");

    // One item at a time: an accepted transaction closes the input.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_ready) |=> !i_ready)
        else $error("input accepted on consecutive cycles");

    // The configuration port never inserts wait states.
    a_no_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready low");

endmodule

bind vector_heading_256_unit vh256_checker u_vh256_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_valid   (i_valid),
    .i_ready   (i_ready),
    .o_valid   (o_valid),
    .o_ready   (o_ready),
    .o_heading (o_heading),
    .pready    (pready)
);

`default_nettype wire
